>>> src/per_bank_page_frame_allocator_defines.svh
// Assertion macros shared by the allocator checker
`ifndef PER_BANK_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PER_BANK_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Assertion that is switched off while reset is held
`define PBFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset
`define PBFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pbfa_pkg.sv
// Types and constants shared by the page frame allocator modules
package pbfa_pkg;

    localparam int NUM_BANKS_DEF   = 16;
    localparam int FRAMES_DEF      = 1024;

    localparam int BANK_W          = 6;
    localparam int FRAME_W         = 15;
    localparam int REQ_W           = 6;
    localparam int RND_W           = 16;
    localparam int ST_W            = 2;
    localparam int POL_W           = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 16;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_POLICY = 3'd0;

    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_ALLOC_BANK = 2'd1,
        OP_FREE       = 2'd2,
        OP_RESERVED   = 2'd3
    } t_opcode;

    localparam logic [POL_W-1:0] POL_RANDOM    = 2'd0;
    localparam logic [POL_W-1:0] POL_HIGHEST   = 2'd1;
    localparam logic [POL_W-1:0] POL_REQUESTER = 2'd2;
    localparam logic [POL_W-1:0] POL_RESERVED  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_BANK  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // What the back end has to do with a classified item
    typedef enum logic [1:0] {
        K_DONE  = 2'd0,
        K_ALLOC = 2'd1,
        K_HIGH  = 2'd2,
        K_FREE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BANK_W-1:0]   bank;
        logic [FRAME_W-1:0]  frame;
        logic [ST_W-1:0]     status;
    } t_cmd;

endpackage

>>> src/pbfa_queue.sv
// Short command queue between the front and back ends
module pbfa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbfa_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output pbfa_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import pbfa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/pbfa_front.sv
// Front end: accepts items, picks or checks the bank, classifies the work
module pbfa_front #(
    parameter int NUM_BANKS       = pbfa_pkg::NUM_BANKS_DEF,
    parameter int FRAMES_PER_BANK = pbfa_pkg::FRAMES_DEF
) (
    input  logic                           i_valid,
    output logic                           o_ready,
    input  pbfa_pkg::t_opcode              i_opcode,
    input  logic [pbfa_pkg::REQ_W-1:0]     i_requester,
    input  logic [pbfa_pkg::RND_W-1:0]     i_random,
    input  logic [pbfa_pkg::FRAME_W-1:0]   i_freed,
    input  logic [pbfa_pkg::POL_W-1:0]     i_policy,
    input  logic                           i_q_full,
    output logic                           o_push,
    output pbfa_pkg::t_cmd                 o_cmd
);
    import pbfa_pkg::*;

    localparam logic [REQ_W-1:0]   REQ_LIMIT   = REQ_W'(NUM_BANKS - 1);
    localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(NUM_BANKS);
    // Rounded-up reciprocals scaled by 2^32; exact for every 16-bit dividend
    localparam logic [31:0] RND_RECIP =
        32'(((64'd1 << 32) + 64'(NUM_BANKS) - 64'd1) / 64'(NUM_BANKS));
    localparam logic [31:0] FR_RECIP  =
        32'(((64'd1 << 32) + 64'(FRAMES_PER_BANK) - 64'd1) / 64'(FRAMES_PER_BANK));

    logic [BANK_W-1:0]    rnd_bank;
    logic [RND_W+31:0]    rnd_prod;
    logic [RND_W-1:0]     rnd_quot;
    logic [RND_W-1:0]     rnd_rem;
    logic [FRAME_W+31:0]  fr_prod;
    logic [FRAME_W-1:0]   fr_m1;
    logic [FRAME_W-1:0]   fr_bank;
    logic                 req_ok;
    logic                 fr_ok;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign rnd_prod = (RND_W+32)'(i_random) * (RND_W+32)'(RND_RECIP);
    assign rnd_quot = rnd_prod[RND_W+31:32];
    assign rnd_rem  = i_random - rnd_quot * RND_W'(NUM_BANKS);
    assign rnd_bank = BANK_W'(rnd_rem);
    assign fr_m1    = i_freed - 1'b1;
    assign fr_prod  = (FRAME_W+32)'(fr_m1) * (FRAME_W+32)'(FR_RECIP);
    assign fr_bank  = fr_prod[FRAME_W+31:32];
    assign req_ok   = (i_requester <= REQ_LIMIT);
    assign fr_ok    = (i_freed != '0) && (fr_bank < FRAME_LIMIT);

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = K_DONE;
        o_cmd.status = ST_OK;
        case (i_opcode)
            OP_ALLOC: begin
                case (i_policy)
                    POL_RANDOM: begin
                        o_cmd.kind = K_ALLOC;
                        o_cmd.bank = rnd_bank;
                    end
                    POL_HIGHEST: begin
                        o_cmd.kind = K_HIGH;
                    end
                    POL_REQUESTER: begin
                        if (req_ok) begin
                            o_cmd.kind = K_ALLOC;
                            o_cmd.bank = BANK_W'(i_requester);
                        end else begin
                            o_cmd.status = ST_BAD_BANK;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_BAD_BANK;
                    end
                endcase
            end
            OP_ALLOC_BANK: begin
                if (req_ok) begin
                    o_cmd.kind = K_ALLOC;
                    o_cmd.bank = BANK_W'(i_requester);
                end else begin
                    o_cmd.status = ST_BAD_BANK;
                end
            end
            OP_FREE: begin
                if (fr_ok) begin
                    o_cmd.kind  = K_FREE;
                    o_cmd.bank  = BANK_W'(fr_bank);
                    o_cmd.frame = i_freed;
                end else begin
                    o_cmd.status = ST_BAD_BANK;
                end
            end
            default: begin
                o_cmd.kind = K_DONE;
            end
        endcase
    end

endmodule

>>> src/pbfa_back.sv
// Back end: per-bank countdowns, free-list rings and the result register
module pbfa_back #(
    parameter int NUM_BANKS       = pbfa_pkg::NUM_BANKS_DEF,
    parameter int FRAMES_PER_BANK = pbfa_pkg::FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pbfa_pkg::t_cmd                i_q_data,
    output logic                          o_q_pop,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [pbfa_pkg::FRAME_W-1:0]  o_frame,
    output logic [pbfa_pkg::ST_W-1:0]     o_status
);
    import pbfa_pkg::*;

    localparam int BW    = $clog2(NUM_BANKS);
    localparam int FC_W  = $clog2(FRAMES_PER_BANK + 1);
    localparam int PTR_W = $clog2(FRAMES_PER_BANK);
    localparam int AW    = $clog2(NUM_BANKS * FRAMES_PER_BANK);
    localparam int MW    = (FC_W + BW > FRAME_W) ? FC_W + BW : FRAME_W;
    localparam int DEPTH = NUM_BANKS * FRAMES_PER_BANK;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEMRD
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic [BW-1:0]       r_bank;
    logic [FRAME_W-1:0]  r_frame_in;
    logic [ST_W-1:0]     r_status_in;

    logic [FC_W-1:0]     r_fresh [NUM_BANKS];
    logic [NUM_BANKS-1:0] r_fresh_ok;
    logic [PTR_W-1:0]    r_head  [NUM_BANKS];
    logic [PTR_W-1:0]    r_tail  [NUM_BANKS];
    logic [FC_W-1:0]     r_occ   [NUM_BANKS];

    logic                r_out_valid;
    logic [FRAME_W-1:0]  r_out_frame;
    logic [ST_W-1:0]     r_out_status;

    logic [FRAME_W-1:0]  r_mem [DEPTH];
    logic [FRAME_W-1:0]  r_rd_data;

    logic [BW-1:0]       hi_bank;
    logic                hi_any;
    logic                fresh_hit;
    logic                occ_nz;
    logic                occ_full;
    logic [FC_W-1:0]     fresh_dec;
    logic [MW-1:0]       fresh_frame;
    logic                mem_re;
    logic                mem_we;
    logic [PTR_W-1:0]    mem_ptr;
    logic [AW-1:0]       mem_addr;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FRAMES_PER_BANK - 1)) ? '0 : p + 1'b1;
    endfunction

    // Highest bank whose countdown still has fresh frames
    always_comb begin
        hi_bank = '0;
        hi_any  = 1'b0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            if (r_fresh_ok[i]) begin
                hi_bank = BW'(i);
                hi_any  = 1'b1;
            end
        end
    end

    assign fresh_hit   = r_fresh_ok[r_bank];
    assign occ_nz      = (r_occ[r_bank] != '0);
    assign occ_full    = (r_occ[r_bank] == FC_W'(FRAMES_PER_BANK));
    assign fresh_dec   = r_fresh[r_bank] - 1'b1;
    assign fresh_frame = MW'(r_fresh[r_bank]) + MW'(FRAMES_PER_BANK) * MW'(r_bank);

    assign mem_re   = (r_state == S_EXEC) && (r_kind == K_ALLOC) && !fresh_hit && occ_nz;
    assign mem_we   = (r_state == S_EXEC) && (r_kind == K_FREE) && !occ_full;
    assign mem_ptr  = (r_kind == K_FREE) ? r_tail[r_bank] : r_head[r_bank];
    assign mem_addr = AW'(r_bank) * AW'(FRAMES_PER_BANK) + AW'(mem_ptr);

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign o_m_valid = r_out_valid;
    assign o_frame   = r_out_frame;
    assign o_status  = r_out_status;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_frame_in;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fresh_ok  <= '1;
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_fresh[i] <= FC_W'(FRAMES_PER_BANK);
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_occ[i]   <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_m_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_q_pop) begin
                        r_frame_in <= i_q_data.frame;
                        // Resolve the highest-bank policy against current counts
                        if ((i_q_data.kind == K_HIGH) && hi_any) begin
                            r_kind      <= K_ALLOC;
                            r_bank      <= hi_bank;
                            r_status_in <= i_q_data.status;
                        end else if (i_q_data.kind == K_HIGH) begin
                            r_kind      <= K_DONE;
                            r_bank      <= BW'(i_q_data.bank);
                            r_status_in <= ST_EXHAUSTED;
                        end else begin
                            r_kind      <= i_q_data.kind;
                            r_bank      <= BW'(i_q_data.bank);
                            r_status_in <= i_q_data.status;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_kind)
                        K_ALLOC: begin
                            if (fresh_hit) begin
                                r_out_frame        <= FRAME_W'(fresh_frame);
                                r_out_status       <= ST_OK;
                                r_out_valid        <= 1'b1;
                                r_state            <= S_IDLE;
                                r_fresh[r_bank]    <= fresh_dec;
                                r_fresh_ok[r_bank] <= (fresh_dec > FC_W'(1));
                            end else if (occ_nz) begin
                                // Hold the result until the ring entry comes back
                                r_head[r_bank] <= ring_next(r_head[r_bank]);
                                r_occ[r_bank]  <= r_occ[r_bank] - 1'b1;
                                r_state        <= S_MEMRD;
                            end else begin
                                r_out_frame  <= '0;
                                r_out_status <= ST_EXHAUSTED;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                        K_FREE: begin
                            r_out_frame <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                            if (occ_full) begin
                                r_out_status <= ST_FULL;
                            end else begin
                                r_out_status   <= ST_OK;
                                r_tail[r_bank] <= ring_next(r_tail[r_bank]);
                                r_occ[r_bank]  <= r_occ[r_bank] + 1'b1;
                            end
                        end
                        default: begin
                            r_out_frame  <= '0;
                            r_out_status <= r_status_in;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    endcase
                end
                S_MEMRD: begin
                    r_out_frame  <= r_rd_data;
                    r_out_status <= ST_OK;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/per_bank_page_frame_allocator.sv
// Page frame allocator over NUM_BANKS banks: each bank first counts down fresh frames
// (bank*FRAMES_PER_BANK+k, k from FRAMES_PER_BANK down to 2), then serves its FIFO free
// list. The front end takes one item a cycle, while the queue has room, into a two-entry
// queue; the back end works on one item at a time (pop, execute, result register), adding
// a memory read when the frame comes from the free list. The free-list memory holds
// NUM_BANKS*FRAMES_PER_BANK frames of 15 bits and needs no clearing pass after reset.
module per_bank_page_frame_allocator #(
    parameter int NUM_BANKS       = pbfa_pkg::NUM_BANKS_DEF,
    parameter int FRAMES_PER_BANK = pbfa_pkg::FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // requester [5:0], random_value [21:6], freed_frame [36:22], zero [39:37]
    input  logic [pbfa_pkg::IN_TDATA_W-1:0]   s_tdata,
    // opcode [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_number [14:0], zero [15]
    output logic [pbfa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [pbfa_pkg::ST_W-1:0]         m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbfa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pbfa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pbfa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pbfa_pkg::*;

    logic [POL_W-1:0]   r_policy;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;
    t_cmd               front_cmd;
    t_cmd               q_cmd;
    logic [FRAME_W-1:0] out_frame;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_POLICY) ? APB_DATA_W'(r_policy) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_RANDOM;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_POLICY)) begin
            r_policy <= pwdata[POL_W-1:0];
        end
    end

    pbfa_front #(
        .NUM_BANKS       (NUM_BANKS),
        .FRAMES_PER_BANK (FRAMES_PER_BANK)
    ) u_front (
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_opcode    (t_opcode'(s_tuser)),
        .i_requester (s_tdata[5:0]),
        .i_random    (s_tdata[21:6]),
        .i_freed     (s_tdata[36:22]),
        .i_policy    (r_policy),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    pbfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    pbfa_back #(
        .NUM_BANKS       (NUM_BANKS),
        .FRAMES_PER_BANK (FRAMES_PER_BANK)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_frame   (out_frame),
        .o_status  (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'(out_frame);

endmodule

>>> src/pbfa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level
`include "per_bank_page_frame_allocator_defines.svh"

module pbfa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pbfa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [pbfa_pkg::ST_W-1:0]         m_tuser
);
    import pbfa_pkg::*;

    // A failed request never hands out a frame
    `PBFA_ASSERT(a_fail_no_frame, i_clk, i_rst_n, (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0), "failed item carries a frame")

    // A stalled result holds
    `PBFA_ASSERT(a_out_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

    // Reset drops any pending result
    `PBFA_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind per_bank_page_frame_allocator pbfa_checker u_pbfa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
